// File: rtl/vgaac_pkg.sv
// Shared types, codes and helper functions for the VGA attribute controller.
package vgaac_pkg;

   // Palette geometry
   localparam int unsigned PALETTE_SLOTS = 16;
   localparam int unsigned SLOT_W        = $clog2(PALETTE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PALETTE_SLOTS - 1);

   // Bus operation codes
   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_READ_INDEX = 2'd1;
   localparam logic [1:0] OP_READ_DATA  = 2'd2;
   localparam logic [1:0] OP_RESET_FF   = 2'd3;

   // Attribute register indexes above the palette
   localparam logic [4:0] IDX_MODE_CONTROL = 5'h10;
   localparam logic [4:0] IDX_OVERSCAN     = 5'h11;
   localparam logic [4:0] IDX_PLANE_ENABLE = 5'h12;
   localparam logic [4:0] IDX_PANNING      = 5'h13;
   localparam logic [4:0] IDX_COLOR_SEL    = 5'h14;

   // Video mode codes (anything else counts as "other")
   localparam logic [1:0] VM_TEXT   = 2'd0;
   localparam logic [1:0] VM_8BIT   = 2'd1;

   // CSR register indexes
   localparam logic CSR_IS_VGA     = 1'b0;
   localparam logic CSR_VIDEO_MODE = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_MAP,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // capture transaction, prefetch indexed palette entry
      logic execute;    // apply register updates, latch notices
      logic fetch;      // read first palette entry of the slot walk
      logic map_load;   // load a mapping result, advance the walk
      logic emit_load;  // load the single plain result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_map;   // executed write reports slot mappings
      logic map_last;   // current slot is the final one
      logic out_free;   // output register can take a result this cycle
   } status_type;

   // DAC index of one palette entry
   function automatic logic [7:0] dac_index(input logic [5:0] entry,
                                            input logic       use_cs_high,
                                            input logic [7:0] csel);
      logic [7:0] c;
      c = {2'b00, entry};
      if (use_cs_high) begin
         c = {csel[3:0], entry[3:0]};
      end
      c[7:6] = c[7:6] | csel[3:2];
      return c;
   endfunction

   // Pixel shift in text mode; nine-dot characters add one
   function automatic logic [3:0] text_panning(input logic [7:0] v,
                                               input logic       nine_dot);
      logic [3:0] p;
      if (v > 8'd7) begin
         p = 4'd0;
      end else begin
         p = v[3:0] + {3'b000, nine_dot};
      end
      return p;
   endfunction

endpackage

// File: rtl/vgaac_req_if.sv
// Bus access channel: operation code and write byte.
interface vgaac_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] bus_data;

   modport source (output valid, output opcode, output bus_data, input ready);
   modport sink   (input valid, input opcode, input bus_data, output ready);
endinterface

// File: rtl/vgaac_rsp_if.sv
// Result channel: read data, palette mapping and display notices.
interface vgaac_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       map_valid;
   logic [3:0] map_slot;
   logic [7:0] map_dac_index;
   logic       panning_valid;
   logic [3:0] pan_shift;
   logic       blink_changed;
   logic       blink_enable;
   logic       mode_redetect;
   logic       last;

   modport source (output valid, output read_data, output map_valid, output map_slot,
                   output map_dac_index, output panning_valid, output pan_shift,
                   output blink_changed, output blink_enable, output mode_redetect,
                   output last, input ready);
   modport sink   (input valid, input read_data, input map_valid, input map_slot,
                   input map_dac_index, input panning_valid, input pan_shift,
                   input blink_changed, input blink_enable, input mode_redetect,
                   input last, output ready);
endinterface

// File: rtl/vgaac_ctrl.sv
// Sequencer: steps each bus transaction through execute, then either the slot walk or the plain result output.
module vgaac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vgaac_pkg::status_type  status,
   output vgaac_pkg::cmd_type     cmd
);

   vgaac_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vgaac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         vgaac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = vgaac_pkg::ST_EXEC;
            end
         end
         vgaac_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = status.need_map ? vgaac_pkg::ST_FETCH : vgaac_pkg::ST_EMIT;
         end
         vgaac_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = vgaac_pkg::ST_MAP;
         end
         vgaac_pkg::ST_MAP: begin
            if (status.out_free) begin
               cmd.map_load = 1'b1;
               if (status.map_last) begin
                  state_in = vgaac_pkg::ST_IDLE;
               end
            end
         end
         vgaac_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = vgaac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vgaac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/vgaac_dpath.sv
// Attribute registers, palette memory, DAC index mapping and result register.
module vgaac_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_is_vga,
   input  logic [1:0]             cfg_video_mode,
   input  logic [1:0]             req_opcode,
   input  logic [7:0]             req_bus_data,
   input  vgaac_pkg::cmd_type     cmd,
   output vgaac_pkg::status_type  status,
   vgaac_rsp_if.source            rsp_chan
);

   localparam int unsigned SW = vgaac_pkg::SLOT_W;

   // Captured transaction
   logic [1:0] op_ff;
   logic [7:0] data_ff;

   // Architectural state
   logic       addr_phase_ff, addr_phase_in;
   logic [4:0] reg_index_ff, reg_index_in;
   logic       pal_source_ff, pal_source_in;
   logic [7:0] mode_ctrl_ff, mode_ctrl_in;
   logic [7:0] overscan_ff, overscan_in;
   logic [7:0] plane_en_ff, plane_en_in;
   logic [3:0] panning_ff, panning_in;
   logic [7:0] color_sel_ff, color_sel_in;

   // Palette memory, valid bits stand for the zero reset value
   logic [5:0]                       pal_mem [vgaac_pkg::PALETTE_SLOTS];
   logic [vgaac_pkg::PALETTE_SLOTS-1:0] pal_valid_ff;
   logic [5:0]                       pal_rdata_ff;
   logic                             pal_we;
   logic                             pal_re;
   logic [SW-1:0]                    pal_raddr;

   // Latched results of the executed transaction
   logic [7:0] rd_ff, rd_in;
   logic       pan_v_ff, pan_v_in;
   logic [3:0] pan_ff, pan_in;
   logic       blink_ch_ff, blink_ch_in;
   logic       redet_ff, redet_in;
   logic [SW-1:0] slot_ff;
   logic          single_ff;

   logic       remap_all;
   logic       one_slot;
   logic [7:0] new_mode;
   logic [7:0] mode_diff;
   logic [SW-1:0] slot_next;

   // Output register
   logic       out_valid_ff;
   logic [7:0] out_read_data_ff;
   logic       out_map_valid_ff;
   logic [3:0] out_map_slot_ff;
   logic [7:0] out_dac_ff;
   logic       out_pan_v_ff;
   logic [3:0] out_pan_ff;
   logic       out_blink_ch_ff;
   logic       out_blink_en_ff;
   logic       out_redet_ff;
   logic       out_last_ff;

   // Register update for the captured transaction
   always_comb begin
      addr_phase_in = addr_phase_ff;
      reg_index_in  = reg_index_ff;
      pal_source_in = pal_source_ff;
      mode_ctrl_in  = mode_ctrl_ff;
      overscan_in   = overscan_ff;
      plane_en_in   = plane_en_ff;
      panning_in    = panning_ff;
      color_sel_in  = color_sel_ff;
      pal_we        = 1'b0;
      remap_all     = 1'b0;
      one_slot      = 1'b0;
      rd_in         = 8'd0;
      pan_v_in      = 1'b0;
      pan_in        = 4'd0;
      blink_ch_in   = 1'b0;
      redet_in      = 1'b0;
      new_mode      = cfg_is_vga ? data_ff : {3'b000, data_ff[4:0]};
      mode_diff     = mode_ctrl_ff ^ new_mode;
      case (op_ff)
         vgaac_pkg::OP_WRITE: begin
            if (addr_phase_ff) begin
               addr_phase_in = 1'b0;
               reg_index_in  = data_ff[4:0];
               pal_source_in = data_ff[5];
            end else begin
               addr_phase_in = 1'b1;
               if (!reg_index_ff[4]) begin
                  if (!pal_source_ff) begin
                     pal_we   = 1'b1;
                     one_slot = 1'b1;
                  end
               end else begin
                  case (reg_index_ff)
                     vgaac_pkg::IDX_MODE_CONTROL: begin
                        mode_ctrl_in = new_mode;
                        remap_all    = mode_diff[7];
                        blink_ch_in  = mode_diff[3];
                        redet_in     = mode_diff[6] | mode_diff[0];
                        if (mode_diff[2] && (cfg_video_mode == vgaac_pkg::VM_TEXT)) begin
                           pan_v_in = 1'b1;
                           pan_in   = vgaac_pkg::text_panning({4'd0, panning_ff},
                                                              new_mode[2]);
                        end
                     end
                     vgaac_pkg::IDX_OVERSCAN: begin
                        overscan_in = data_ff;
                     end
                     vgaac_pkg::IDX_PLANE_ENABLE: begin
                        remap_all   = (plane_en_ff[3:0] != data_ff[3:0]);
                        plane_en_in = data_ff;
                     end
                     vgaac_pkg::IDX_PANNING: begin
                        panning_in = data_ff[3:0];
                        pan_v_in   = 1'b1;
                        if (cfg_video_mode == vgaac_pkg::VM_TEXT) begin
                           pan_in = vgaac_pkg::text_panning(data_ff, mode_ctrl_ff[2]);
                        end else if (cfg_video_mode == vgaac_pkg::VM_8BIT) begin
                           pan_in = {2'b00, data_ff[2:1]};
                        end else begin
                           pan_in = {1'b0, data_ff[2:0]};
                        end
                     end
                     vgaac_pkg::IDX_COLOR_SEL: begin
                        if (!cfg_is_vga) begin
                           color_sel_in = 8'd0;
                        end else if (color_sel_ff != data_ff) begin
                           color_sel_in = data_ff;
                           remap_all    = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         vgaac_pkg::OP_READ_INDEX: begin
            rd_in = {2'b00, pal_source_ff, reg_index_ff};
         end
         vgaac_pkg::OP_READ_DATA: begin
            if (!reg_index_ff[4]) begin
               rd_in = {2'b00, pal_rdata_ff};
            end else begin
               case (reg_index_ff)
                  vgaac_pkg::IDX_MODE_CONTROL: rd_in = mode_ctrl_ff;
                  vgaac_pkg::IDX_OVERSCAN:     rd_in = overscan_ff;
                  vgaac_pkg::IDX_PLANE_ENABLE: rd_in = plane_en_ff;
                  vgaac_pkg::IDX_PANNING:      rd_in = {4'd0, panning_ff};
                  vgaac_pkg::IDX_COLOR_SEL:    rd_in = color_sel_ff;
                  default:                     rd_in = 8'd0;
               endcase
            end
         end
         vgaac_pkg::OP_RESET_FF: begin
            addr_phase_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Status to the sequencer
   assign status.need_map = remap_all | one_slot;
   assign status.map_last = single_ff | (slot_ff == vgaac_pkg::LAST_SLOT);
   assign status.out_free = !out_valid_ff | rsp_chan.ready;

   // Palette read address: indexed entry on capture, plane-masked slot on the walk
   assign slot_next = slot_ff + SW'(1);
   always_comb begin
      pal_re    = 1'b0;
      pal_raddr = reg_index_ff[SW-1:0];
      if (cmd.accept) begin
         pal_re    = 1'b1;
         pal_raddr = reg_index_ff[SW-1:0];
      end else if (cmd.fetch) begin
         pal_re    = 1'b1;
         pal_raddr = slot_ff & plane_en_ff[SW-1:0];
      end else if (cmd.map_load && !status.map_last) begin
         pal_re    = 1'b1;
         pal_raddr = slot_next & plane_en_ff[SW-1:0];
      end
   end

   // Palette memory
   always_ff @(posedge clock) begin
      if (cmd.execute && pal_we) begin
         pal_mem[reg_index_ff[SW-1:0]] <= data_ff[5:0];
      end
      if (pal_re) begin
         pal_rdata_ff <= pal_valid_ff[pal_raddr] ? pal_mem[pal_raddr] : 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (cmd.execute && pal_we) begin
         pal_valid_ff[reg_index_ff[SW-1:0]] <= 1'b1;
      end
   end

   // Control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_phase_ff <= 1'b1;
         reg_index_ff  <= 5'd0;
         pal_source_ff <= 1'b0;
         mode_ctrl_ff  <= 8'd0;
         overscan_ff   <= 8'd0;
         plane_en_ff   <= 8'd0;
         panning_ff    <= 4'd0;
         color_sel_ff  <= 8'd0;
      end else if (cmd.execute) begin
         addr_phase_ff <= addr_phase_in;
         reg_index_ff  <= reg_index_in;
         pal_source_ff <= pal_source_in;
         mode_ctrl_ff  <= mode_ctrl_in;
         overscan_ff   <= overscan_in;
         plane_en_ff   <= plane_en_in;
         panning_ff    <= panning_in;
         color_sel_ff  <= color_sel_in;
      end
   end

   // Transaction capture, latched notices and slot walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_opcode;
         data_ff <= req_bus_data;
      end
      if (cmd.execute) begin
         rd_ff       <= rd_in;
         pan_v_ff    <= pan_v_in;
         pan_ff      <= pan_in;
         blink_ch_ff <= blink_ch_in;
         redet_ff    <= redet_in;
         slot_ff     <= remap_all ? SW'(0) : reg_index_ff[SW-1:0];
         single_ff   <= !remap_all;
      end else if (cmd.map_load && !status.map_last) begin
         slot_ff <= slot_next;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.map_load || cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload; notices ride on the final result only
   always_ff @(posedge clock) begin
      if (cmd.map_load) begin
         out_read_data_ff <= status.map_last ? rd_ff : 8'd0;
         out_map_valid_ff <= 1'b1;
         out_map_slot_ff  <= 4'(slot_ff);
         out_dac_ff       <= vgaac_pkg::dac_index(pal_rdata_ff, mode_ctrl_ff[7],
                                                  color_sel_ff);
         out_pan_v_ff     <= status.map_last & pan_v_ff;
         out_pan_ff       <= status.map_last ? pan_ff : 4'd0;
         out_blink_ch_ff  <= status.map_last & blink_ch_ff;
         out_blink_en_ff  <= mode_ctrl_ff[3];
         out_redet_ff     <= status.map_last & redet_ff;
         out_last_ff      <= status.map_last;
      end else if (cmd.emit_load) begin
         out_read_data_ff <= rd_ff;
         out_map_valid_ff <= 1'b0;
         out_map_slot_ff  <= 4'd0;
         out_dac_ff       <= 8'd0;
         out_pan_v_ff     <= pan_v_ff;
         out_pan_ff       <= pan_ff;
         out_blink_ch_ff  <= blink_ch_ff;
         out_blink_en_ff  <= mode_ctrl_ff[3];
         out_redet_ff     <= redet_ff;
         out_last_ff      <= 1'b1;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.read_data     = out_read_data_ff;
   assign rsp_chan.map_valid     = out_map_valid_ff;
   assign rsp_chan.map_slot      = out_map_slot_ff;
   assign rsp_chan.map_dac_index = out_dac_ff;
   assign rsp_chan.panning_valid = out_pan_v_ff;
   assign rsp_chan.pan_shift     = out_pan_ff;
   assign rsp_chan.blink_changed = out_blink_ch_ff;
   assign rsp_chan.blink_enable  = out_blink_en_ff;
   assign rsp_chan.mode_redetect = out_redet_ff;
   assign rsp_chan.last          = out_last_ff;

endmodule

// File: rtl/vga_attribute_controller_core.sv
// Top level of the VGA attribute controller: CSR port, sequencer and datapath.
//
// Each bus transaction on req_chan (3C0 write, 3C0 read, 3C1 read or flip-flop
// reset) produces one result on rsp_chan, or sixteen when a write changes the
// whole palette mapping (mode control bit 7, plane enable bits 3..0 or color
// select). The sequencer handles one transaction at a time, stepping it through
// accept in idle, execute, then the result load. A palette write adds a fetch
// step to read the entry back before its result; a remapping write walks all
// sixteen slots, since the slot walk goes through the single palette read port
// one slot per cycle while the output register can take a result. The result
// load waits while the output register still holds an unaccepted result. A new
// transaction is accepted once the sequencer is back in idle, while the last
// result may still wait in the output register. The machine class and video
// mode are CSRs at byte addresses 0 and 4.
module vga_attribute_controller_core (
   input  logic        clock,
   input  logic        reset,
   vgaac_req_if.sink   req_chan,
   vgaac_rsp_if.source rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       is_vga_ff;
   logic [1:0] video_mode_ff;
   logic       csr_write;
   logic       csr_index;

   vgaac_pkg::cmd_type    cmd;
   vgaac_pkg::status_type status;

   // CSR access
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_vga_ff     <= 1'b1;
         video_mode_ff <= vgaac_pkg::VM_TEXT;
      end else if (csr_write) begin
         case (csr_index)
            vgaac_pkg::CSR_IS_VGA:     is_vga_ff     <= pwdata[0];
            vgaac_pkg::CSR_VIDEO_MODE: video_mode_ff <= pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         vgaac_pkg::CSR_IS_VGA:     prdata = {31'd0, is_vga_ff};
         vgaac_pkg::CSR_VIDEO_MODE: prdata = {30'd0, video_mode_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   vgaac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vgaac_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg_is_vga     (is_vga_ff),
      .cfg_video_mode (video_mode_ff),
      .req_opcode     (req_chan.opcode),
      .req_bus_data   (req_chan.bus_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_chan       (rsp_chan)
   );

endmodule
